@@ sv/jfif_dimension_scanner_assert.svh @@
// Assertion macros used by the checker file.
`ifndef JFIF_DIMENSION_SCANNER_ASSERT_SVH
`define JFIF_DIMENSION_SCANNER_ASSERT_SVH

// Immediate-cycle implication, checked at every edge outside reset.
`define JDS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every edge outside reset.
`define JDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jds_pkg.sv @@
package jds_pkg;

    // Input beat: one file byte plus end-of-file flag
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic        status;
        logic [15:0] px_width;
        logic [15:0] px_height;
    } out_beat_t;

    // Parser result toward the output register
    typedef struct packed {
        logic      valid;
        out_beat_t beat;
    } res_t;

    // Parse phases
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_SKIP   = 3'd1,
        PH_MARK0  = 3'd2,
        PH_MARK1  = 3'd3,
        PH_LENHI  = 3'd4,
        PH_LENLO  = 3'd5,
        PH_SOF    = 3'd6
    } phase_t;

    localparam logic STATUS_FOUND   = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam logic [7:0] MARKER_PREFIX = 8'hFF;
    localparam logic [7:0] SOI_CODE      = 8'hD8;
    localparam logic [7:0] APP0_CODE     = 8'hE0;
    localparam logic [7:0] SOF0_CODE     = 8'hC0;
    localparam logic [7:0] CHAR_J        = 8'h4A;
    localparam logic [7:0] CHAR_F        = 8'h46;
    localparam logic [7:0] CHAR_I        = 8'h49;
    localparam logic [7:0] NUL_BYTE      = 8'h00;

    // Header and SOF0 byte offsets
    localparam logic [3:0] HDR_LEN_HI_OFS = 4'd4;
    localparam logic [3:0] HDR_LEN_LO_OFS = 4'd5;
    localparam logic [3:0] HDR_LAST_OFS   = 4'd10;
    localparam logic [3:0] SOF_FIRST_OFS  = 4'd2;
    localparam logic [3:0] SOF_H_HI_OFS   = 4'd5;
    localparam logic [3:0] SOF_H_LO_OFS   = 4'd6;
    localparam logic [3:0] SOF_W_HI_OFS   = 4'd7;
    localparam logic [3:0] SOF_W_LO_OFS   = 4'd8;

    // APP0 length covers bytes 4..10; other segments cover their length field
    localparam logic [15:0] HDR_LEN_MIN = 16'd7;
    localparam logic [15:0] SEG_LEN_MIN = 16'd2;

    // Expected header byte at a given offset (length bytes are not compared)
    function automatic logic [7:0] hdr_expect(input logic [3:0] ofs);
        logic [7:0] v;
        case (ofs)
            4'd0:    v = MARKER_PREFIX;
            4'd1:    v = SOI_CODE;
            4'd2:    v = MARKER_PREFIX;
            4'd3:    v = APP0_CODE;
            4'd6:    v = CHAR_J;
            4'd7:    v = CHAR_F;
            4'd8:    v = CHAR_I;
            4'd9:    v = CHAR_F;
            default: v = NUL_BYTE;
        endcase
        return v;
    endfunction

endpackage

@@ sv/jds_parser.sv @@
module jds_parser
    import jds_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     step,
    input  in_beat_t beat,
    output res_t     res
);

    phase_t      phase_reg, phase_next;
    logic [3:0]  ofs_reg, ofs_next;
    logic [15:0] skip_reg, skip_next;
    logic [7:0]  len_hi_reg, len_hi_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  width_hi_reg, width_hi_next;
    logic        decided_reg, decided_next;

    logic [7:0]  b;
    logic [15:0] seg_len;
    logic        fail;
    logic        found;

    assign b       = beat.data_byte;
    assign seg_len = {len_hi_reg, b};

    // Decision for the current byte
    always_comb
    begin
        fail  = 1'b0;
        found = 1'b0;
        case (phase_reg)
            PH_HEADER:
            begin
                if (ofs_reg != HDR_LEN_HI_OFS && ofs_reg != HDR_LEN_LO_OFS
                    && b != hdr_expect(ofs_reg))
                    fail = 1'b1;
                if (ofs_reg >= HDR_LAST_OFS && skip_reg < HDR_LEN_MIN)
                    fail = 1'b1;
            end
            PH_SKIP:   fail = 1'b0;
            PH_MARK0:  fail = (b != MARKER_PREFIX);
            PH_MARK1:  fail = 1'b0;
            PH_LENHI:  fail = 1'b0;
            PH_LENLO:  fail = (seg_len < SEG_LEN_MIN);
            PH_SOF:    found = (ofs_reg >= SOF_W_LO_OFS);
            default:   fail = 1'b1;
        endcase
    end

    // Result; the last byte forces invalid if nothing was decided
    always_comb
    begin
        res.valid          = !decided_reg && (fail || found || beat.last_byte);
        res.beat.status    = found ? STATUS_FOUND : STATUS_INVALID;
        res.beat.px_width  = found ? {width_hi_reg, b} : 16'd0;
        res.beat.px_height = found ? height_reg : 16'd0;
    end

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        ofs_next      = ofs_reg;
        skip_next     = skip_reg;
        len_hi_next   = len_hi_reg;
        height_next   = height_reg;
        width_hi_next = width_hi_reg;
        decided_next  = decided_reg;
        if (step)
        begin
            if (beat.last_byte)
            begin
                phase_next    = PH_HEADER;
                ofs_next      = 4'd0;
                skip_next     = 16'd0;
                len_hi_next   = 8'd0;
                height_next   = 16'd0;
                width_hi_next = 8'd0;
                decided_next  = 1'b0;
            end
            else if (!decided_reg)
            begin
                if (fail || found)
                    decided_next = 1'b1;
                else
                begin
                    case (phase_reg)
                        PH_HEADER:
                        begin
                            if (ofs_reg == HDR_LEN_HI_OFS)
                                len_hi_next = b;
                            if (ofs_reg == HDR_LEN_LO_OFS)
                                skip_next = seg_len;
                            if (ofs_reg >= HDR_LAST_OFS)
                            begin
                                skip_next  = skip_reg - HDR_LEN_MIN;
                                phase_next = (skip_reg != HDR_LEN_MIN) ? PH_SKIP : PH_MARK0;
                                ofs_next   = 4'd0;
                            end
                            else
                                ofs_next = ofs_reg + 4'd1;
                        end
                        PH_SKIP:
                        begin
                            skip_next = skip_reg - 16'd1;
                            if (skip_reg == 16'd1)
                                phase_next = PH_MARK0;
                        end
                        PH_MARK0:  phase_next = PH_MARK1;
                        PH_MARK1:
                        begin
                            if (b == SOF0_CODE)
                            begin
                                phase_next = PH_SOF;
                                ofs_next   = SOF_FIRST_OFS;
                            end
                            else
                                phase_next = PH_LENHI;
                        end
                        PH_LENHI:
                        begin
                            len_hi_next = b;
                            phase_next  = PH_LENLO;
                        end
                        PH_LENLO:
                        begin
                            skip_next  = seg_len - SEG_LEN_MIN;
                            phase_next = (seg_len != SEG_LEN_MIN) ? PH_SKIP : PH_MARK0;
                        end
                        PH_SOF:
                        begin
                            if (ofs_reg == SOF_H_HI_OFS)
                                height_next = {b, 8'd0};
                            if (ofs_reg == SOF_H_LO_OFS)
                                height_next = {height_reg[15:8], b};
                            if (ofs_reg == SOF_W_HI_OFS)
                                width_hi_next = b;
                            ofs_next = ofs_reg + 4'd1;
                        end
                        default:   decided_next = 1'b1;
                    endcase
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            ofs_reg      <= 4'd0;
            skip_reg     <= 16'd0;
            len_hi_reg   <= 8'd0;
            height_reg   <= 16'd0;
            width_hi_reg <= 8'd0;
            decided_reg  <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            ofs_reg      <= ofs_next;
            skip_reg     <= skip_next;
            len_hi_reg   <= len_hi_next;
            height_reg   <= height_next;
            width_hi_reg <= width_hi_next;
            decided_reg  <= decided_next;
        end
    end

endmodule

@@ sv/jds_out_reg.sv @@
module jds_out_reg
    import jds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  res_t      res,
    output logic      result_valid,
    input  logic      result_ready,
    output out_beat_t result_beat
);

    logic      valid_reg, valid_next;
    out_beat_t beat_reg, beat_next;

    // A step only happens when this register is empty or draining
    always_comb
    begin
        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (step)
        begin
            valid_next = res.valid;
            beat_next  = res.beat;
        end
        else if (result_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        beat_reg <= beat_next;
    end

    assign result_valid = valid_reg;
    assign result_beat  = beat_reg;

endmodule

@@ sv/jfif_dimension_scanner.sv @@
// Channel   Direction  Handshake                    Beat
// byte      in         byte_valid / byte_ready      in_beat_t  (data_byte, last_byte)
// result    out        result_valid / result_ready  out_beat_t (status, width, height)
//
// One byte per cycle unless the result stalls; a result is registered.
// The rate is set by the combinational parse step between input and result register.
// Reset clears the parser to the header check; no clearing pass.
// A stalled result holds the parser; one more byte is buffered in the input register.
module jfif_dimension_scanner
    import jds_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      byte_valid,
    output logic      byte_ready,
    input  in_beat_t  byte_beat,
    output logic      result_valid,
    input  logic      result_ready,
    output out_beat_t result_beat
);

    logic     in_valid_reg, in_valid_next;
    in_beat_t in_reg, in_next;
    logic     step;
    res_t     res;

    // Parse the held byte when the result slot can take its outcome
    assign step       = in_valid_reg && (!result_valid || result_ready);
    assign byte_ready = !in_valid_reg || step;

    // Input register
    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_next       = in_reg;
        if (byte_ready)
        begin
            in_valid_next = byte_valid;
            in_next       = byte_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        in_reg <= in_next;
    end

    jds_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .beat  (in_reg),
        .res   (res)
    );

    jds_out_reg u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .res          (res),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

endmodule

@@ sv/jds_checker.sv @@
`include "jfif_dimension_scanner_assert.svh"

module jds_checker
    import jds_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      byte_ready,
    input logic      result_valid,
    input logic      result_ready,
    input out_beat_t result_beat
);

    logic res_invalid;
    logic res_zero_size;
    logic res_stall;

    assign res_invalid   = result_valid && result_beat.status == STATUS_INVALID;
    assign res_zero_size = result_beat.px_width == 16'd0 && result_beat.px_height == 16'd0;
    assign res_stall     = result_valid && !result_ready;

    // Invalid results carry zero dimensions
    `JDS_ASSERT_NOW(a_invalid_zero, res_invalid, res_zero_size, "invalid result, nonzero size")

    // Input backpressure only comes from a stalled result
    `JDS_ASSERT_NOW(a_ready_cause, !byte_ready, res_stall, "input stalled without result stall")

    // A stalled result beat holds
    `JDS_ASSERT_NEXT(a_result_hold, res_stall, result_valid && $stable(result_beat),
        "stalled result changed")

endmodule

bind jfif_dimension_scanner jds_checker u_jds_checker (.*);
